FILE: sv/tt_pkg.sv
// shared types and constants for the trickle timer unit
package tt_pkg;

    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 16;

    typedef enum logic [2:0] {
        OP_TICK         = 3'd0,
        OP_EQUIVALENT   = 3'd1,
        OP_LOCAL_NEWER  = 3'd2,
        OP_REMOTE_NEWER = 3'd3,
        OP_INCOMPARABLE = 3'd4,
        OP_RESTART      = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        CFG_MIN_INTERVAL   = 2'd0,
        CFG_MAX_INTERVAL   = 2'd1,
        CFG_REDUNDANCY_THR = 2'd2
    } cfg_index_t;

    localparam logic [31:0] MIN_INTERVAL_RST   = 32'd100;
    localparam logic [31:0] MAX_INTERVAL_RST   = 32'd65536;
    localparam logic [15:0] REDUNDANCY_THR_RST = 16'd3;

    typedef struct packed {
        logic [31:0] min_interval;
        logic [31:0] max_interval;
        logic [15:0] redundancy_threshold;
    } cfg_t;

    typedef struct packed {
        logic        summary_tx;
        logic        update_tx;
        logic        summary_suppressed;
        logic        interval_started;
        logic [31:0] interval_length;
        logic [15:0] heard_consistent;
    } result_t;

endpackage

FILE: sv/tt_cfg.sv
// configuration register file of the trickle timer unit
module tt_cfg
    import tt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_INTERVAL:   cfg_next.min_interval         = cfg_data;
                CFG_MAX_INTERVAL:   cfg_next.max_interval         = cfg_data;
                CFG_REDUNDANCY_THR: cfg_next.redundancy_threshold = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval         <= MIN_INTERVAL_RST;
            cfg_reg.max_interval         <= MAX_INTERVAL_RST;
            cfg_reg.redundancy_threshold <= REDUNDANCY_THR_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: sv/tt_core.sv
// trickle timer state and single-pass update logic
module tt_core
    import tt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [2:0]  opcode,
    input  logic [31:0] random_value,
    input  cfg_t        cfg,
    output result_t     result
);

    localparam int LW = (TIME_BITS > 32) ? TIME_BITS + 1 : 33;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [TIME_BITS-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  running_reg,  running_next;
    logic [TIME_BITS-1:0]  elapsed_reg,  elapsed_next;
    logic [TIME_BITS-1:0]  interval_reg, interval_next;
    logic [TIME_BITS-1:0]  tpoint_reg,   tpoint_next;
    logic                  done_reg,     done_next;
    logic [COUNT_BITS-1:0] count_reg,    count_next;

    logic [TIME_BITS-1:0] elapsed_inc;
    logic [LW-1:0]        cur_w, max_w, min_w, dbl_w;
    logic [LW-1:0]        len_raw, len_nz, len_sat, half;
    logic [31:0]          span;
    logic [63:0]          prod;
    logic [TIME_BITS-1:0] tpoint_new;
    logic                 start, use_min, fire;
    logic                 f_sum, f_upd, f_sup;

    // interval length for the next interval, then transmit point placement
    always_comb begin
        cur_w = LW'(interval_reg);
        max_w = LW'(cfg.max_interval);
        min_w = LW'(cfg.min_interval);
        if (cur_w > (max_w >> 1)) begin
            dbl_w = max_w;
        end else if ((cur_w << 1) > max_w) begin
            dbl_w = max_w;
        end else begin
            dbl_w = cur_w << 1;
        end
        len_raw    = use_min ? min_w : dbl_w;
        len_nz     = (len_raw == '0) ? LW'(1) : len_raw;
        len_sat    = (len_nz > LW'(TIME_MAX)) ? LW'(TIME_MAX) : len_nz;
        half       = len_sat >> 1;
        span       = 32'(len_sat - half);
        prod       = random_value * span;
        tpoint_new = TIME_BITS'(half + LW'(prod[63:32]));
    end

    always_comb begin
        elapsed_inc = (elapsed_reg == TIME_MAX) ? elapsed_reg : elapsed_reg + 1'b1;

        running_next  = running_reg;
        elapsed_next  = elapsed_reg;
        interval_next = interval_reg;
        tpoint_next   = tpoint_reg;
        done_next     = done_reg;
        count_next    = count_reg;
        start         = 1'b0;
        use_min       = 1'b1;
        f_sum         = 1'b0;
        f_upd         = 1'b0;
        f_sup         = 1'b0;

        if (opcode == OP_RESTART) begin
            running_next = 1'b1;
            start        = 1'b1;
        end else if (running_reg) begin
            unique case (opcode_t'(opcode))
                OP_TICK: begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= interval_reg) begin
                        start   = 1'b1;
                        use_min = 1'b0;
                    end
                end
                OP_EQUIVALENT: begin
                    if (count_reg != COUNT_MAX) begin
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_LOCAL_NEWER: begin
                    f_upd = 1'b1;
                end
                OP_REMOTE_NEWER: begin
                    start = 1'b1;
                    f_sum = 1'b1;
                end
                OP_INCOMPARABLE: begin
                    f_upd = 1'b1;
                    start = 1'b1;
                    f_sum = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (start) begin
            interval_next = TIME_BITS'(len_sat);
            elapsed_next  = '0;
            tpoint_next   = tpoint_new;
            done_next     = 1'b0;
            count_next    = '0;
        end

        // a fresh interval has its transmit point at zero only for length one
        fire = running_next && !done_next &&
               (start ? (len_sat == LW'(1)) : (elapsed_next >= tpoint_reg));
        if (fire) begin
            done_next = 1'b1;
            if (CW'(count_next) < CW'(cfg.redundancy_threshold)) begin
                f_sum = 1'b1;
            end else begin
                f_sup = 1'b1;
            end
        end

        result.summary_tx         = f_sum;
        result.update_tx          = f_upd;
        result.summary_suppressed = f_sup;
        result.interval_started   = start;
        result.interval_length    = 32'(interval_next);
        result.heard_consistent   = 16'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg  <= 1'b0;
            elapsed_reg  <= '0;
            interval_reg <= '0;
            tpoint_reg   <= '0;
            done_reg     <= 1'b0;
            count_reg    <= '0;
        end else if (step) begin
            running_reg  <= running_next;
            elapsed_reg  <= elapsed_next;
            interval_reg <= interval_next;
            tpoint_reg   <= tpoint_next;
            done_reg     <= done_next;
            count_reg    <= count_next;
        end
    end

    a_running_len: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> interval_reg != '0)
        else $error("running timer with zero interval");

    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !running_reg |-> (elapsed_reg == '0 && count_reg == '0 && !done_reg))
        else $error("idle timer holds stale state");

    a_restart_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && opcode == OP_RESTART) |=> running_reg)
        else $error("restart did not start the timer");

endmodule

FILE: sv/trickle_timer_unit.sv
// trickle timer unit top level: input stage, timer core, result register
// an accepted transaction waits in the input stage, then its core result is registered
// throughput: one transaction per cycle while m_ready is high; the input stage takes
// one more item while a finished result waits on the result register
// reset: synchronous active-low aresetn clears both stages and the timer,
// which stays idle until a restart; configuration returns to its defaults
module trickle_timer_unit
    import tt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [31:0] s_random_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_summary_tx,
    output logic        m_update_tx,
    output logic        m_summary_suppressed,
    output logic        m_interval_started,
    output logic [31:0] m_interval_length,
    output logic [15:0] m_heard_consistent,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg;
    result_t core_result;

    logic        in_valid_reg, in_valid_next;
    logic [2:0]  in_opcode_reg;
    logic [31:0] in_random_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_result_reg;
    logic        out_free, advance, in_take;

    tt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tt_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .opcode       (in_opcode_reg),
        .random_value (in_random_reg),
        .cfg          (cfg),
        .result       (core_result)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign in_take  = s_valid && s_ready;

    always_comb begin
        priority if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        priority if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_opcode_reg <= s_opcode;
            in_random_reg <= s_random_value;
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_summary_tx         = out_result_reg.summary_tx;
    assign m_update_tx          = out_result_reg.update_tx;
    assign m_summary_suppressed = out_result_reg.summary_suppressed;
    assign m_interval_started   = out_result_reg.interval_started;
    assign m_interval_length    = out_result_reg.interval_length;
    assign m_heard_consistent   = out_result_reg.heard_consistent;

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced transaction missing from result register");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !advance)
        else $error("pending result overwritten");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> !in_take)
        else $error("input stage overwritten while held");

endmodule

FILE: dv/trickle_timer_unit_test.sv
// self-checking testbench for the trickle timer unit
`timescale 1ns / 1ps

module trickle_timer_unit_test;
    import tt_pkg::*;

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;
    localparam logic [1:0] CFG_SPARE   = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] rnd;
    } timer_item_t;

    typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_MOSTLY} ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = OP_TICK;
    logic [31:0] s_random_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_summary_tx;
    logic        m_update_tx;
    logic        m_summary_suppressed;
    logic        m_interval_started;
    logic [31:0] m_interval_length;
    logic [15:0] m_heard_consistent;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_MIN_INTERVAL;
    logic [31:0] cfg_data = '0;

    trickle_timer_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_random_value       (s_random_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_summary_tx         (m_summary_tx),
        .m_update_tx          (m_update_tx),
        .m_summary_suppressed (m_summary_suppressed),
        .m_interval_started   (m_interval_started),
        .m_interval_length    (m_interval_length),
        .m_heard_consistent   (m_heard_consistent),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // timer state mirror
    logic [31:0] lim_min = MIN_INTERVAL_RST;
    logic [31:0] lim_max = MAX_INTERVAL_RST;
    logic [15:0] lim_thr = REDUNDANCY_THR_RST;
    logic        tm_running = 1'b0;
    logic [31:0] tm_elapsed = '0;
    logic [31:0] tm_interval = '0;
    logic [31:0] tm_tx_point = '0;
    logic        tm_tx_done = 1'b0;
    logic [15:0] tm_heard = '0;

    timer_item_t items_to_send[$];
    result_t     timer_results_due[$];

    bit          in_taken = 1'b0;
    bit          cfg_taken = 1'b0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          stall_left = 0;
    int          ready_phase = 0;
    ready_mode_t stall_mode = READY_ALWAYS;
    timer_item_t next_item;
    result_t     got;
    result_t     want;

    int failures = 0;
    int cycle_count = 0;
    int items_accepted = 0;
    int results_seen = 0;
    int summaries_sent = 0;
    int summaries_suppressed = 0;
    int updates_sent = 0;
    int intervals_started = 0;
    int settings_used = 1;

    function automatic void open_interval(input logic [31:0] len, input logic [31:0] rnd);
        logic [31:0] half;
        logic [31:0] span;
        logic [63:0] prod;
        if (len == 32'd0)
            len = 32'd1;
        half = len >> 1;
        span = len - half;
        prod = {32'd0, rnd} * {32'd0, span};
        tm_interval = len;
        tm_elapsed  = '0;
        tm_tx_point = half + prod[63:32];
        tm_tx_done  = 1'b0;
        tm_heard    = '0;
    endfunction

    function automatic result_t advance_timer(input logic [2:0] op, input logic [31:0] rnd);
        result_t     r;
        logic [32:0] doubled;
        logic [31:0] grown;
        r = '0;
        if (op == OP_RESTART) begin
            tm_running = 1'b1;
            open_interval(lim_min, rnd);
            r.interval_started = 1'b1;
        end else if (tm_running) begin
            case (op)
                OP_TICK: begin
                    if (tm_elapsed != 32'hFFFF_FFFF)
                        tm_elapsed++;
                    if (tm_elapsed >= tm_interval) begin
                        if (tm_interval > (lim_max >> 1)) begin
                            grown = lim_max;
                        end else begin
                            doubled = {tm_interval, 1'b0};
                            grown = (doubled > {1'b0, lim_max}) ? lim_max : doubled[31:0];
                        end
                        open_interval(grown, rnd);
                        r.interval_started = 1'b1;
                    end
                end
                OP_EQUIVALENT: begin
                    if (tm_heard != 16'hFFFF)
                        tm_heard++;
                end
                OP_LOCAL_NEWER: begin
                    r.update_tx = 1'b1;
                end
                OP_REMOTE_NEWER, OP_INCOMPARABLE: begin
                    if (op == OP_INCOMPARABLE)
                        r.update_tx = 1'b1;
                    open_interval(lim_min, rnd);
                    r.interval_started = 1'b1;
                    r.summary_tx = 1'b1;
                end
                default: ;
            endcase
        end
        if (tm_running && !tm_tx_done && tm_elapsed >= tm_tx_point) begin
            tm_tx_done = 1'b1;
            if (tm_heard < lim_thr)
                r.summary_tx = 1'b1;
            else
                r.summary_suppressed = 1'b1;
        end
        r.interval_length  = tm_interval;
        r.heard_consistent = tm_heard;
        return r;
    endfunction

    task automatic report_failure(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        failures++;
    endtask

    task automatic check_field(input string field, input logic [31:0] seen,
                               input logic [31:0] needed);
        if (seen !== needed)
            report_failure($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                     results_seen, field, seen, needed));
    endtask

    // acceptance, prediction and result checking
    always @(posedge aclk) begin
        in_taken = 1'b0;
        cfg_taken = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                cfg_taken = 1'b1;
                case (cfg_index)
                    CFG_MIN_INTERVAL:   lim_min = cfg_data;
                    CFG_MAX_INTERVAL:   lim_max = cfg_data;
                    CFG_REDUNDANCY_THR: lim_thr = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                items_accepted++;
                timer_results_due = {timer_results_due,
                                     advance_timer(s_opcode, s_random_value)};
            end
            if (m_valid && m_ready) begin
                got = {m_summary_tx, m_update_tx, m_summary_suppressed,
                       m_interval_started, m_interval_length, m_heard_consistent};
                if (timer_results_due.size() == 0) begin
                    report_failure($sformatf("result %0d arrived with nothing pending",
                                             results_seen));
                end else begin
                    want = timer_results_due[0];
                    timer_results_due.delete(0);
                    check_field("summary_tx", got.summary_tx, want.summary_tx);
                    check_field("update_tx", got.update_tx, want.update_tx);
                    check_field("summary_suppressed", got.summary_suppressed,
                                want.summary_suppressed);
                    check_field("interval_started", got.interval_started,
                                want.interval_started);
                    check_field("interval_length", got.interval_length, want.interval_length);
                    check_field("heard_consistent", got.heard_consistent,
                                want.heard_consistent);
                    summaries_sent       += want.summary_tx;
                    summaries_suppressed += want.summary_suppressed;
                    updates_sent         += want.update_tx;
                    intervals_started    += want.interval_started;
                end
                results_seen++;
            end
        end
    end

    // input driver in bursts, result-side backpressure
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                if (gap_left > 0) begin
                    s_valid <= 1'b0;
                    gap_left--;
                end else if (items_to_send.size() != 0) begin
                    next_item = items_to_send[0];
                    items_to_send.delete(0);
                    s_valid        <= 1'b1;
                    s_opcode       <= next_item.op;
                    s_random_value <= next_item.rnd;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
            if (stall_left == 0) begin
                stall_mode = ready_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(16, 160);
            end else begin
                stall_left--;
            end
            ready_phase++;
            case (stall_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                READY_SPARSE: m_ready <= (ready_phase % 4 == 0);
                default:      m_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_item(input logic [2:0] op, input logic [31:0] rnd);
        timer_item_t it;
        it.op  = op;
        it.rnd = rnd;
        items_to_send = {items_to_send, it};
    endtask

    // restart followed by a random mix, ticks mostly in runs
    task automatic queue_sequence(input int n);
        int          left;
        int          run;
        int          pick;
        logic [2:0]  op;
        left = n - 1;
        queue_item(OP_RESTART, rand_word());
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                run = $urandom_range(1, 12);
                while (run > 0 && left > 0) begin
                    queue_item(OP_TICK, rand_word());
                    run--;
                    left--;
                end
            end else begin
                if (pick < 65)      op = OP_EQUIVALENT;
                else if (pick < 73) op = OP_LOCAL_NEWER;
                else if (pick < 80) op = OP_REMOTE_NEWER;
                else if (pick < 87) op = OP_INCOMPARABLE;
                else if (pick < 93) op = OP_TICK;
                else if (pick < 96) op = OP_RESTART;
                else                op = pick[0] ? OP_SPARE_LO : OP_SPARE_HI;
                queue_item(op, rand_word());
                left--;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge aclk);
        while (items_to_send.size() != 0 || (s_valid && !in_taken) ||
               timer_results_due.size() != 0);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge aclk);
        while (!cfg_taken);
    endtask

    task automatic run_setting(input logic [31:0] lo, input logic [31:0] hi,
                               input logic [15:0] thr, input int n);
        write_register(CFG_MIN_INTERVAL, lo);
        write_register(CFG_MAX_INTERVAL, hi);
        write_register(CFG_REDUNDANCY_THR, {16'($urandom), thr});
        cfg_valid <= 1'b0;
        settings_used++;
        queue_sequence(n);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // idle timer ignores everything but a restart
        queue_item(OP_TICK, 32'd0);
        queue_item(OP_EQUIVALENT, 32'hFFFF_FFFF);
        queue_item(OP_LOCAL_NEWER, 32'd0);
        queue_item(OP_REMOTE_NEWER, 32'hFFFF_FFFF);
        queue_item(OP_INCOMPARABLE, 32'd0);
        queue_item(OP_SPARE_LO, 32'hFFFF_FFFF);
        queue_item(OP_SPARE_HI, 32'd0);
        queue_item(OP_RESTART, 32'd0);
        queue_item(OP_EQUIVALENT, 32'd0);
        queue_item(OP_EQUIVALENT, 32'd0);
        queue_item(OP_EQUIVALENT, 32'd0);
        queue_item(OP_TICK, 32'hFFFF_FFFF);
        queue_item(OP_LOCAL_NEWER, 32'h5555_5555);
        queue_item(OP_SPARE_LO, 32'hAAAA_AAAA);
        queue_item(OP_SPARE_HI, 32'd0);
        queue_item(OP_REMOTE_NEWER, 32'hFFFF_FFFF);
        queue_item(OP_INCOMPARABLE, 32'h8000_0000);
        queue_item(OP_RESTART, 32'hFFFF_FFFF);
        queue_item(OP_RESTART, 32'h0000_0001);
        queue_item(OP_TICK, 32'h7FFF_FFFF);
        wait_drained();
        queue_sequence(200);
        wait_drained();

        // an unmapped register index must leave the settings alone
        write_register(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;

        run_setting(32'd1, 32'd8, 16'd1, 110);
        run_setting(32'd2, 32'd32, 16'd2, 110);
        run_setting(32'd0, 32'd0, 16'd0, 80);
        run_setting(32'd3, 32'd1000, 16'hFFFF, 110);
        run_setting(32'd10, 32'd4, 16'd3, 80);
        run_setting(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd1, 40);
        run_setting(32'd5, 32'hFFFF_FFFF, 16'd4, 110);
        repeat (3)
            run_setting($urandom_range(0, 12), $urandom_range(0, 200),
                        16'($urandom_range(0, 5)), 90);
        run_setting(MIN_INTERVAL_RST, MAX_INTERVAL_RST, REDUNDANCY_THR_RST, 150);

        repeat (8) @(negedge aclk);
        if (timer_results_due.size() != 0)
            report_failure($sformatf("%0d results never arrived", timer_results_due.size()));

        $display("%0d transactions in, %0d results out, across %0d timer settings",
                 items_accepted, results_seen, settings_used);
        $display("summaries %0d sent / %0d suppressed, updates %0d, interval starts %0d",
                 summaries_sent, summaries_suppressed, updates_sent, intervals_started);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: trickle_timer_unit.f
sv/tt_pkg.sv
sv/tt_cfg.sv
sv/tt_core.sv
sv/trickle_timer_unit.sv
dv/trickle_timer_unit_test.sv
